### rtl/assert_macros.svh
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define AST_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Checked on every edge, reset included.
`define AST_ANY(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

### rtl/rop_pkg.sv
package rop_pkg;

    localparam int MAX_RECTS = 128;
    localparam int IDX_W     = $clog2(MAX_RECTS);
    localparam int CNT_W     = $clog2(MAX_RECTS + 1);

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int GLYPH_W = 8;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 8;

    localparam logic               ACT_LOAD   = 1'b0;
    localparam logic               ACT_QUERY  = 1'b1;
    localparam logic [GLYPH_W-1:0] SPACE_CHAR = 8'd32;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [ROW_W-1:0]   bottom_row;
        logic [COL_W-1:0]   right_col;
        logic [ROW_W-1:0]   top_row;
        logic [COL_W-1:0]   left_col;
    } t_rect;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_rect            wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

### rtl/rop_table_ram.sv
module rop_table_ram (
    input  logic              i_clk,
    input  rop_pkg::t_ram_req i_req,
    output rop_pkg::t_rect    o_rd_data
);
    import rop_pkg::*;

    t_rect r_mem [MAX_RECTS];
    t_rect r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/rop_ctrl.sv
module rop_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic                          i_action,
    input  rop_pkg::t_rect                i_rect,
    input  logic [rop_pkg::ROW_W-1:0]     i_query_row,
    input  logic [rop_pkg::COL_W-1:0]     i_query_col,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [rop_pkg::GLYPH_W-1:0]   o_cell_char,
    output logic                          o_covered,
    output rop_pkg::t_ram_req             o_req,
    input  rop_pkg::t_rect                i_rd_data
);
    import rop_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [GLYPH_W-1:0] r_char, n_char;
    logic               r_hit, n_hit;
    logic               r_m_valid, n_m_valid;
    logic [GLYPH_W-1:0] r_out_char, n_out_char;
    logic               r_out_cov, n_out_cov;
    logic               w_accept;
    logic               w_cover;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_cover = (i_rd_data.left_col <= r_col) && (i_rd_data.right_col >= r_col) &&
                     (i_rd_data.top_row <= r_row) && (i_rd_data.bottom_row >= r_row);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_row      = r_row;
        n_col      = r_col;
        n_char     = r_char;
        n_hit      = r_hit;
        n_m_valid  = r_m_valid && !i_m_tready;
        n_out_char = r_out_char;
        n_out_cov  = r_out_cov;
        o_req.we    = 1'b0;
        o_req.waddr = r_count[IDX_W-1:0];
        o_req.wdata = i_rect;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_LOAD) begin
                        if (r_count != CNT_W'(MAX_RECTS)) begin
                            o_req.we = 1'b1;
                            n_count  = r_count + 1'b1;
                        end
                    end else begin
                        n_row  = i_query_row;
                        n_col  = i_query_col;
                        n_char = SPACE_CHAR;
                        n_hit  = 1'b0;
                        if (r_count == '0) begin
                            n_state = ST_DONE;
                        end else begin
                            n_idx   = r_count - 1'b1;
                            n_state = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (w_cover) begin
                    n_char  = i_rd_data.glyph;
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else if (r_idx == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid  = 1'b1;
                    n_out_char = r_char;
                    n_out_cov  = r_hit;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_req.raddr = n_idx[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_row      <= n_row;
        r_col      <= n_col;
        r_char     <= n_char;
        r_hit      <= n_hit;
        r_out_char <= n_out_char;
        r_out_cov  <= n_out_cov;
    end

    assign o_m_tvalid  = r_m_valid;
    assign o_cell_char = r_out_char;
    assign o_covered   = r_out_cov;

endmodule

### rtl/rectangle_overlay_pixel_lookup_top.sv
// Rectangle overlay lookup: painter's-order compositing of up to 128 rectangles.
// Slave stream: one beat per item; tuser picks load (0) or query (1).
//   Load appends a rectangle (bounds inclusive, glyph byte) and
//   returns nothing; a load into a full table is dropped.
// Master stream: one beat per query; tdata is the cell character, tuser the
//   covered flag. Uncovered cells return a space with covered low.
// Timing: a query walks the table newest first, one entry per cycle through
//   the table RAM's single read port, and stops at the first hit. It examines
//   from one entry up to the stored count, or none when the table is empty,
//   then passes through the done state, which loads the result register.
//   The slave side is not ready while a query is in flight; it is ready
//   again once the result register loads.
// Stall: the result waits in the output register; a new item is accepted
//   meanwhile, and a following query holds in its last step until the
//   register frees.
// Reset: the rectangle count and output valid clear; the table needs no
//   clearing since only stored entries are ever read.
module rectangle_overlay_pixel_lookup_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // left_col, top_row, right_col, bottom_row, glyph, query_row, query_col
    input  logic [rop_pkg::S_DATA_W-1:0]   i_s_tdata,
    // action
    input  logic [0:0]                     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // cell_char
    output logic [rop_pkg::M_DATA_W-1:0]   o_m_tdata,
    // covered
    output logic [0:0]                     o_m_tuser
);
    import rop_pkg::*;

    t_rect              w_rect;
    t_rect              w_rd_data;
    t_ram_req           w_req;
    logic [ROW_W-1:0]   w_query_row;
    logic [COL_W-1:0]   w_query_col;
    logic               w_covered;

    assign w_rect.left_col   = i_s_tdata[6:0];
    assign w_rect.top_row    = i_s_tdata[11:7];
    assign w_rect.right_col  = i_s_tdata[18:12];
    assign w_rect.bottom_row = i_s_tdata[23:19];
    assign w_rect.glyph      = i_s_tdata[31:24];
    assign w_query_row       = i_s_tdata[36:32];
    assign w_query_col       = i_s_tdata[43:37];

    rop_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_action    (i_s_tuser[0]),
        .i_rect      (w_rect),
        .i_query_row (w_query_row),
        .i_query_col (w_query_col),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_cell_char (o_m_tdata),
        .o_covered   (w_covered),
        .o_req       (w_req),
        .i_rd_data   (w_rd_data)
    );

    rop_table_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    assign o_m_tuser[0] = w_covered;

endmodule

### rtl/rop_checker.sv
`include "assert_macros.svh"

module rop_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_tvalid,
    input logic                         o_s_tready,
    input logic [rop_pkg::S_DATA_W-1:0] i_s_tdata,
    input logic [0:0]                   i_s_tuser,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [rop_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic [0:0]                   o_m_tuser
);
    import rop_pkg::*;

    logic w_query_beat;

    assign w_query_beat = i_s_tvalid && o_s_tready && (i_s_tuser[0] == ACT_QUERY);

    `AST_ANY(a_reset_no_out, !i_rst_n |=> !o_m_tvalid)
    `AST_CLK(a_uncovered_space, (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == SPACE_CHAR))
    `AST_CLK(a_query_busy, w_query_beat |=> !o_s_tready)
    `AST_CLK(a_no_instant_result, (i_s_tvalid && o_s_tready) |=> !$rose(o_m_tvalid))
    `AST_CLK(a_out_hold, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))

endmodule

bind rectangle_overlay_pixel_lookup_top rop_checker u_rop_checker (.*);

### tb/sv/rectangle_overlay_pixel_lookup_checker.sv
`timescale 1ns / 100ps

module rectangle_overlay_pixel_lookup_checker
    import rop_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic [0:0]          i_s_tuser,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [M_DATA_W-1:0] i_m_tdata,
    input  logic [0:0]          i_m_tuser,
    output int                  o_fail_cnt,
    output int                  o_pending
);

    typedef struct packed {
        logic [GLYPH_W-1:0] cell_char;
        logic               covered;
    } t_cell;

    t_rect       layers [MAX_RECTS];
    int unsigned layer_cnt = 0;
    t_cell       cell_q [$];
    int          fail_cnt = 0;

    assign o_fail_cnt = fail_cnt;
    assign o_pending  = cell_q.size();

    // topmost layer wins: scan newest to oldest, bounds inclusive
    function automatic t_cell paint_cell(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        t_cell res;
        res.cell_char = SPACE_CHAR;
        res.covered   = 1'b0;
        for (int i = int'(layer_cnt) - 1; i >= 0; i--) begin
            if (layers[i].left_col <= col && layers[i].right_col >= col &&
                layers[i].top_row <= row && layers[i].bottom_row >= row) begin
                res.cell_char = layers[i].glyph;
                res.covered   = 1'b1;
                break;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_cell want;
        if (!i_rst_n) begin
            layer_cnt = 0;
            cell_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (cell_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: unexpected result beat char=%h covered=%b",
                                 $realtime, i_m_tdata, i_m_tuser);
                end else begin
                    want = cell_q.pop_front();
                    if (want.cell_char !== i_m_tdata || want.covered !== i_m_tuser[0]) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("%0t: mismatch exp char=%h covered=%b, got char=%h covered=%b",
                                     $realtime, want.cell_char, want.covered,
                                     i_m_tdata, i_m_tuser);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == ACT_QUERY) begin
                    cell_q.push_back(paint_cell(i_s_tdata[36:32], i_s_tdata[43:37]));
                end else if (layer_cnt < MAX_RECTS) begin
                    layers[layer_cnt] = t_rect'(i_s_tdata[31:0]);
                    layer_cnt++;
                end
            end
        end
    end

endmodule

### tb/sv/tb_rectangle_overlay_pixel_lookup_top.sv
`timescale 1ns / 100ps

module tb_rectangle_overlay_pixel_lookup_top;
    import rop_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 50;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [S_DATA_W-1:0] s_data = '0;
    logic [0:0]          s_user = ACT_LOAD;
    logic                m_valid;
    logic                m_ready = 1'b1;
    logic [M_DATA_W-1:0] m_data;
    logic [0:0]          m_user;

    int fail_cnt;
    int pending;
    bit calm = 1'b0;
    int stall_left = 0;
    int run_left = 0;

    always #10 i_clk = ~i_clk;

    rectangle_overlay_pixel_lookup_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tuser  (m_user)
    );

    rectangle_overlay_pixel_lookup_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .i_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .i_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .i_m_tdata  (m_data),
        .i_m_tuser  (m_user),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    // result-side backpressure: stall bursts between runs of ready
    always @(negedge i_clk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (run_left > 0) begin
            run_left <= run_left - 1;
            m_ready  <= 1'b1;
        end else begin
            stall_left <= $urandom_range(17, 1) - 1;
            run_left   <= ($urandom_range(3) == 0) ? 300 : $urandom_range(40, 1);
            m_ready    <= 1'b0;
        end
    end

    // called at a falling edge, returns at a falling edge after the beat
    task automatic send_beat(logic act, t_rect r, logic [ROW_W-1:0] row,
                             logic [COL_W-1:0] col);
        int gap;
        if (!calm && $urandom_range(3) == 0) begin
            gap = $urandom_range(17, 1);
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= act;
        s_data  <= {4'b0, col, row, r};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_rect(int l, int t, int r, int b, int g);
        t_rect rect;
        rect.left_col   = COL_W'(l);
        rect.top_row    = ROW_W'(t);
        rect.right_col  = COL_W'(r);
        rect.bottom_row = ROW_W'(b);
        rect.glyph      = GLYPH_W'(g);
        send_beat(ACT_LOAD, rect, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic query_cell(int row, int col);
        send_beat(ACT_QUERY, t_rect'($urandom), ROW_W'(row), COL_W'(col));
    endtask

    task automatic random_item();
        int mode;
        int l;
        int t;
        mode = $urandom_range(99);
        if ($urandom_range(99) < 55) begin
            if (mode < 85)
                query_cell($urandom_range(24), $urandom_range(79));
            else
                query_cell($urandom, $urandom);
        end else if (mode < 80) begin
            l = $urandom_range(79);
            t = $urandom_range(24);
            load_rect(l, t, $urandom_range(79, l), $urandom_range(24, t), $urandom);
        end else if (mode < 90) begin
            load_rect($urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (mode < 95) begin
            l = $urandom_range(79);
            t = $urandom_range(24);
            load_rect(l, t, l, t, $urandom);
        end else begin
            load_rect(0, 0, 79, 24, $urandom);
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table
        query_cell(0, 0);
        query_cell(31, 127);
        // full grid, corners and just outside
        load_rect(0, 0, 79, 24, 8'hFF);
        query_cell(0, 0);
        query_cell(24, 79);
        query_cell(25, 0);
        // inverted columns, then inverted rows: cover nothing
        load_rect(50, 5, 10, 20, 8'h41);
        query_cell(10, 30);
        load_rect(0, 20, 79, 3, 8'h42);
        query_cell(10, 30);
        // single cell, glyph zero
        load_rect(79, 24, 79, 24, 8'h00);
        query_cell(24, 79);
        query_cell(24, 78);
        // beyond the grid, field maxima
        load_rect(80, 25, 127, 31, 8'h20);
        query_cell(31, 127);
        query_cell(25, 80);
        // inclusive edges
        load_rect(10, 2, 20, 4, 8'h55);
        query_cell(3, 15);
        query_cell(2, 10);
        query_cell(4, 20);
        query_cell(5, 21);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                s_valid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            random_item();
        end
        s_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (140) @(negedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/rop_pkg.sv
rtl/rop_table_ram.sv
rtl/rop_ctrl.sv
rtl/rectangle_overlay_pixel_lookup_top.sv
rtl/rop_checker.sv
tb/sv/rectangle_overlay_pixel_lookup_checker.sv
tb/sv/tb_rectangle_overlay_pixel_lookup_top.sv
